>>> design/tbia_pkg.sv
// Shared types, codes and lane-mapping helpers for the typed byte image access block.
// No dependencies; imported by every module of the block but tbia_bank.
`default_nettype none

package tbia_pkg;

    localparam int NUM_BANKS = 8;

    // access function codes
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // access size codes
    localparam logic [2:0] SIZE_BIT   = 3'd0;
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_HALF  = 3'd2;
    localparam logic [2:0] SIZE_WORD  = 3'd3;
    localparam logic [2:0] SIZE_DWORD = 3'd4;

    // byte order codes
    localparam logic [1:0] ORDER_BIG        = 2'd0;
    localparam logic [1:0] ORDER_LITTLE     = 2'd1;
    localparam logic [1:0] ORDER_BIG_WSWAP  = 2'd2;
    localparam logic [1:0] ORDER_LIT_WSWAP  = 2'd3;

    // configuration registers
    localparam int         CFG_ADDR_W         = 3;
    localparam logic [0:0] REG_ACTIVE_BYTES   = 1'b0;
    localparam logic [11:0] ACTIVE_BYTES_RST  = 12'd2048;

    localparam logic [7:0] BIT_ONE   = 8'h01;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic        func;
        logic [10:0] start_byte;
        logic [2:0]  access_size;
        logic [1:0]  byte_order;
        logic        sign_extend;
        logic [2:0]  bit_index;
        logic [63:0] write_value;
    } in_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic        range_error;
    } out_t;

    // per-access plan, one lane per bank
    typedef struct packed {
        logic                          func;
        logic                          bit_op;
        logic                          range_error;
        logic                          sign_extend;
        logic                          write_nz;
        logic [3:0]                    len;
        logic [2:0]                    bit_bank;
        logic [2:0]                    bit_index;
        logic [NUM_BANKS-1:0]          lane_en;
        logic [NUM_BANKS-1:0][2:0]     lane_sel;
    } plan_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic logic [3:0] len_of(input logic [2:0] size);
        logic [3:0] len;
        case (size) inside
            SIZE_BIT, SIZE_BYTE: len = 4'd1;
            SIZE_HALF:           len = 4'd2;
            SIZE_WORD:           len = 4'd4;
            SIZE_DWORD:          len = 4'd8;
            default:             len = 4'd0;
        endcase
        return len;
    endfunction

    // value byte (0 = least significant) held at image position p of the access
    function automatic logic [2:0] lane_of(input logic [2:0] p, input logic [3:0] len,
                                           input logic [1:0] order);
        logic [2:0] last;
        logic [2:0] lane;
        last = 3'(len - 4'd1);
        if (len == 4'd1) begin
            lane = 3'd0;
        end else begin
            case (order)
                ORDER_LITTLE:    lane = p;
                ORDER_BIG_WSWAP: lane = p ^ 3'd1;
                ORDER_LIT_WSWAP: lane = (last - p) ^ 3'd1;
                default:         lane = last - p;
            endcase
        end
        return lane;
    endfunction

endpackage

`default_nettype wire

>>> design/tbia_bank.sv
// One byte-wide image bank: single port, registered read data.
// Depends on nothing; instantiated once per byte lane by the top level.
`default_nettype none

module tbia_bank #(
    parameter int ROWS  = 256,
    parameter int ROW_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             re,
    input  wire logic             we,
    input  wire logic [ROW_W-1:0] addr,
    input  wire logic [7:0]       wdata,
    output logic      [7:0]       rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/tbia_plan.sv
// Access planner: range check, bank rows and byte-lane selects for one access.
// Depends on tbia_pkg.
`default_nettype none

module tbia_plan #(
    parameter int IMAGE_BYTES = 2048,
    parameter int ROW_W       = 8
) (
    input  wire tbia_pkg::in_t                              item,
    input  wire logic [11:0]                                active_bytes,
    output tbia_pkg::plan_t                                 plan,
    output logic [tbia_pkg::NUM_BANKS-1:0][ROW_W-1:0]       rows
);
    import tbia_pkg::*;

    localparam int LIM_W = $clog2(IMAGE_BYTES + 1);
    localparam int CMP_W = (LIM_W > 12) ? LIM_W : 12;
    localparam logic [CMP_W-1:0] IMG_LIMIT = CMP_W'(IMAGE_BYTES);

    logic [3:0]       len;
    logic [CMP_W-1:0] active_ext;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] end_pos;
    logic [2:0]       base_bank;
    logic [2:0]       pos;
    logic [8:0]       row_full;

    assign len        = len_of(item.access_size);
    assign active_ext = CMP_W'(active_bytes);
    assign limit      = (active_ext > IMG_LIMIT) ? IMG_LIMIT : active_ext;
    assign end_pos    = CMP_W'(item.start_byte) + CMP_W'(len);
    assign base_bank  = item.start_byte[2:0];

    always_comb begin
        plan.func        = item.func;
        plan.bit_op      = (item.access_size == SIZE_BIT);
        plan.range_error = (len == 4'd0) || (end_pos > limit);
        plan.sign_extend = item.sign_extend;
        plan.write_nz    = (item.write_value != 64'd0);
        plan.len         = len;
        plan.bit_bank    = base_bank;
        plan.bit_index   = item.bit_index;
        pos              = 3'd0;
        row_full         = 9'd0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            // position of this bank within the access, and the row it falls in
            pos              = 3'(b) - base_bank;
            plan.lane_en[b]  = ({1'b0, pos} < len);
            plan.lane_sel[b] = lane_of(pos, len, item.byte_order);
            row_full         = {1'b0, item.start_byte[10:3]}
                             + {8'd0, (3'(b) < base_bank)};
            rows[b]          = ROW_W'(row_full);
        end
    end

endmodule

`default_nettype wire

>>> design/tbia_fmt.sv
// Read formatter: gathers bank bytes into the value, extends it, handles bit reads.
// Depends on tbia_pkg.
`default_nettype none

module tbia_fmt (
    input  wire tbia_pkg::plan_t                        plan,
    input  wire logic [tbia_pkg::NUM_BANKS-1:0][7:0]    rd_bytes,
    output tbia_pkg::out_t                              result
);
    import tbia_pkg::*;

    logic [63:0] gathered;
    logic [63:0] extended;
    logic [7:0]  bit_byte;

    always_comb begin
        gathered = 64'd0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (plan.lane_en[b]) begin
                gathered[{plan.lane_sel[b], 3'b000} +: 8] = rd_bytes[b];
            end
        end
    end

    always_comb begin
        extended = gathered;
        if (plan.sign_extend) begin
            case (plan.len)
                4'd1: if (gathered[7])  extended[63:8]  = '1;
                4'd2: if (gathered[15]) extended[63:16] = '1;
                4'd4: if (gathered[31]) extended[63:32] = '1;
                default: extended = gathered;
            endcase
        end
    end

    assign bit_byte = rd_bytes[plan.bit_bank];

    always_comb begin
        result.range_error = plan.range_error;
        if (plan.range_error || plan.func == FUNC_WRITE) begin
            result.read_value = 64'd0;
        end else if (plan.bit_op) begin
            result.read_value = {56'd0, (bit_byte >> plan.bit_index) & BIT_ONE};
        end else begin
            result.read_value = extended;
        end
    end

endmodule

`default_nettype wire

>>> design/typed_byte_image_access.sv
// Typed byte image access: top level with control sequencer, eight image banks and config port.
// Depends on tbia_pkg, tbia_bank, tbia_plan and tbia_fmt.
// Usage:
//   s_valid/s_ready/s_item carries one access request per transfer: a read or write of a
//   single bit or of 1, 2, 4 or 8 bytes at any byte offset, in one of four byte orders.
//   m_valid/m_ready/m_item returns one result per request: the read value (zero for
//   writes and flagged accesses) and range_error. The APB port holds active_bytes at
//   address 0; accesses ending past it are flagged and leave the image untouched.
// Timing:
//   Each request is accepted, then executed; no new request is taken until it completes.
//   The accept cycle reads one row of each of the eight byte banks (bank = address bits
//   [2:0], so any 8-byte span hits each bank once); the execute state, once the output
//   register is free, gathers, writes back, loads the output register and raises m_valid.
// Reset:
//   A clearing pass zeroes the image, one row of all banks per cycle, over IMAGE_BYTES/8
//   rows rounded up (256 at the default); s_ready stays low until it ends. APB writes
//   are taken during the pass.
// Stall:
//   A result waits in the output register while m_ready is low; one more request is still
//   accepted, and its completion holds until the register frees.
`default_nettype none

module typed_byte_image_access #(
    parameter int IMAGE_BYTES = 2048
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire tbia_pkg::in_t                     s_item,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output tbia_pkg::out_t                         m_item,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbia_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import tbia_pkg::*;

    localparam int ROWS  = (IMAGE_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // control state
    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   clr_row_reg, clr_row_next;
    logic               m_valid_reg, m_valid_next;
    logic [11:0]        active_bytes_reg, active_bytes_next;

    // request held between accept and completion
    plan_t                            plan_reg;
    logic [NUM_BANKS-1:0][ROW_W-1:0]  rows_reg;
    logic [63:0]                      wv_reg;
    out_t                             m_item_reg;

    plan_t                            plan_in;
    logic [NUM_BANKS-1:0][ROW_W-1:0]  rows_in;
    out_t                             fmt_result;

    // bank ports
    logic [NUM_BANKS-1:0]             bank_re;
    logic [NUM_BANKS-1:0]             bank_we;
    logic [NUM_BANKS-1:0][ROW_W-1:0]  bank_addr;
    logic [NUM_BANKS-1:0][7:0]        bank_wdata;
    logic [NUM_BANKS-1:0][7:0]        bank_rdata;

    // sequencer strobes
    logic s_accept;
    logic out_free;
    logic exec_go;
    logic clearing;
    logic cfg_write;

    logic [7:0] bit_mask;
    logic [7:0] bit_new;

    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    //------------------------------------------------------------------
    // planner and formatter
    //------------------------------------------------------------------
    tbia_plan #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .ROW_W       (ROW_W)
    ) u_plan (
        .item         (s_item),
        .active_bytes (active_bytes_reg),
        .plan         (plan_in),
        .rows         (rows_in)
    );

    tbia_fmt u_fmt (
        .plan     (plan_reg),
        .rd_bytes (bank_rdata),
        .result   (fmt_result)
    );

    //------------------------------------------------------------------
    // image banks: bank b holds bytes whose address ends in b
    //------------------------------------------------------------------
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        tbia_bank #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_bank (
            .aclk  (aclk),
            .re    (bank_re[b]),
            .we    (bank_we[b]),
            .addr  (bank_addr[b]),
            .wdata (bank_wdata[b]),
            .rdata (bank_rdata[b])
        );
    end

    //------------------------------------------------------------------
    // sequencer: next state
    //------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_row_reg == LAST_ROW) state_next = ST_IDLE;
            ST_IDLE:  if (s_accept)                state_next = ST_EXEC;
            ST_EXEC:  if (out_free)                state_next = ST_IDLE;
            default:                               state_next = ST_CLEAR;
        endcase
    end

    //------------------------------------------------------------------
    // sequencer: outputs
    //------------------------------------------------------------------
    always_comb begin
        s_ready  = 1'b0;
        exec_go  = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  s_ready  = 1'b1;
            ST_EXEC:  exec_go  = out_free;
            default:  clearing = 1'b0;
        endcase
    end

    // read-modify-write of the addressed byte for bit writes
    assign bit_mask = BIT_ONE << plan_reg.bit_index;
    assign bit_new  = plan_reg.write_nz ? (bank_rdata[plan_reg.bit_bank] | bit_mask)
                                        : (bank_rdata[plan_reg.bit_bank] & (BYTE_MASK ^ bit_mask));

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_re[b]    = s_accept;
            bank_we[b]    = 1'b0;
            bank_addr[b]  = rows_in[b];
            bank_wdata[b] = 8'd0;
            if (clearing) begin
                bank_we[b]   = 1'b1;
                bank_addr[b] = clr_row_reg;
            end else if (state_reg == ST_EXEC) begin
                bank_addr[b] = rows_reg[b];
                if (exec_go && !plan_reg.range_error && plan_reg.func == FUNC_WRITE) begin
                    if (plan_reg.bit_op) begin
                        bank_we[b]    = (3'(b) == plan_reg.bit_bank);
                        bank_wdata[b] = bit_new;
                    end else begin
                        bank_we[b]    = plan_reg.lane_en[b];
                        bank_wdata[b] = wv_reg[{plan_reg.lane_sel[b], 3'b000} +: 8];
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // control registers
    //------------------------------------------------------------------
    always_comb begin
        clr_row_next = clearing ? clr_row_reg + 1'b1 : clr_row_reg;

        m_valid_next = m_valid_reg;
        if (exec_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        active_bytes_next = active_bytes_reg;
        if (cfg_write && paddr[CFG_ADDR_W-1] == REG_ACTIVE_BYTES) begin
            active_bytes_next = pwdata[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_row_reg      <= '0;
            m_valid_reg      <= 1'b0;
            active_bytes_reg <= ACTIVE_BYTES_RST;
        end else begin
            state_reg        <= state_next;
            clr_row_reg      <= clr_row_next;
            m_valid_reg      <= m_valid_next;
            active_bytes_reg <= active_bytes_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            plan_reg <= plan_in;
            rows_reg <= rows_in;
            wv_reg   <= s_item.write_value;
        end
        if (exec_go) begin
            m_item_reg <= fmt_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    //------------------------------------------------------------------
    // APB register access
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_ACTIVE_BYTES) ? {20'd0, active_bytes_reg}
                                                              : 32'd0;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_EXEC)
        else $error("accepted transfer did not move to execute");

    a_no_write_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && plan_reg.range_error) |-> bank_we == '0)
        else $error("flagged access wrote the image");

    a_error_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.range_error) |-> m_item.read_value == 64'd0)
        else $error("flagged access returned nonzero data");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready && bank_we == '1)
        else $error("clearing pass overlapped request traffic");

endmodule

`default_nettype wire

>>> dv/typed_byte_image_access_tb.sv
`timescale 1ns / 1ps
// Testbench for typed_byte_image_access: typed bit/byte/half/word/dword reads and writes
// checked against an in-bench image model, with APB updates of active_bytes.
// Depends on tbia_pkg and the typed_byte_image_access RTL.

module typed_byte_image_access_tb;
    import tbia_pkg::*;

    localparam int IMAGE_BYTES   = 2048;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;      // settling time past the last result
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off for the fill-up test
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;

    localparam logic [2:0] SIZE_CODES [0:4] =
        '{SIZE_BIT, SIZE_BYTE, SIZE_HALF, SIZE_WORD, SIZE_DWORD};
    localparam logic [1:0] ORDER_CODES [0:3] =
        '{ORDER_BIG, ORDER_LITTLE, ORDER_BIG_WSWAP, ORDER_LIT_WSWAP};
    localparam int AREA_PICKS [0:7] = '{1, 2, 8, 9, 300, 2047, 2048, 4095};

    // ---------------------------------------------------------------- DUT signals
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_item;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    typed_byte_image_access #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- model state
    logic [7:0]  image_model [0:IMAGE_BYTES-1];
    logic [11:0] area_model;
    in_t         access_q[$];          // items waiting to be offered
    out_t        access_results_q[$];  // predicted results, oldest first
    int          error_count = 0;
    int          cycle_count = 0;
    bit          hold_req    = 1'b0;   // asks the receiver for a long hold-off

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // bytes touched by an access; 0 means the size code is unused
    function automatic int access_bytes(input logic [2:0] size);
        case (size) inside
            SIZE_BIT, SIZE_BYTE: return 1;
            SIZE_HALF:           return 2;
            SIZE_WORD:           return 4;
            SIZE_DWORD:          return 8;
            default:             return 0;
        endcase
    endfunction

    // image position (from the offset) of value byte j, j = 0 most significant
    function automatic int image_pos(input int j, input int n, input logic [1:0] order);
        if (n < 2)
            return 0;
        case (order)
            ORDER_LITTLE:    return n - 1 - j;
            ORDER_BIG_WSWAP: return 2 * (n / 2 - 1 - j / 2) + (j % 2);
            ORDER_LIT_WSWAP: return j ^ 1;
            default:         return j;
        endcase
    endfunction

    // Applies one access to the image model and returns the result the block owes.
    function automatic out_t predict_access(input in_t a);
        out_t        r;
        int          n;
        int          lim;
        int          p;
        logic [63:0] v;
        logic [7:0]  mask;
        r   = '0;
        n   = access_bytes(a.access_size);
        lim = (int'(area_model) > IMAGE_BYTES) ? IMAGE_BYTES : int'(area_model);
        if (n == 0 || int'(a.start_byte) + n > lim) begin
            r.range_error = 1'b1;
            return r;
        end
        p = int'(a.start_byte);
        if (a.access_size == SIZE_BIT) begin
            mask = BIT_ONE << a.bit_index;
            if (a.func == FUNC_WRITE) begin
                if (a.write_value != 64'd0)
                    image_model[p] = image_model[p] | mask;
                else
                    image_model[p] = image_model[p] & ~mask;
            end else begin
                r.read_value = 64'(image_model[p][a.bit_index]);
            end
        end else if (a.func == FUNC_WRITE) begin
            for (int j = 0; j < n; j++)
                image_model[p + image_pos(j, n, a.byte_order)] =
                    8'((a.write_value >> (8 * (n - 1 - j))) & 64'(BYTE_MASK));
        end else begin
            v = '0;
            for (int j = 0; j < n; j++)
                v = {v[55:0], image_model[p + image_pos(j, n, a.byte_order)]};
            if (a.sign_extend && n < 8 && v[8 * n - 1])
                v = v | ~((64'd1 << (8 * n)) - 64'd1);
            r.read_value = v;
        end
        return r;
    endfunction

    function automatic in_t make_access(input logic func, input int off, input logic [2:0] size,
                                        input logic [1:0] order, input logic sext,
                                        input int bit_idx, input logic [63:0] value);
        in_t a;
        a.func        = func;
        a.start_byte  = 11'(off);
        a.access_size = size;
        a.byte_order  = order;
        a.sign_extend = sext;
        a.bit_index   = 3'(bit_idx);
        a.write_value = value;
        return a;
    endfunction

    function automatic logic [63:0] random_value();
        case ($urandom_range(0, 9))
            0, 1:    return 64'd0;
            2:       return 64'(8'($urandom)) << (8 * $urandom_range(0, 7));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly in-range accesses; window mode keeps reads landing on written bytes.
    function automatic in_t random_access(input int lim, input int base);
        in_t a;
        int  n;
        int  off;
        a.func        = 1'($urandom);
        a.byte_order  = ORDER_CODES[$urandom_range(0, 3)];
        a.sign_extend = 1'($urandom);
        a.bit_index   = 3'($urandom);
        a.write_value = random_value();
        case ($urandom_range(0, 19))
            0: begin
                a.access_size = 3'($urandom_range(5, 7));
                a.start_byte  = 11'($urandom);
            end
            1: begin
                a.access_size = 3'($urandom);
                a.start_byte  = 11'($urandom);
            end
            default: begin
                a.access_size = SIZE_CODES[$urandom_range(0, 4)];
                n = access_bytes(a.access_size);
                if (lim < n) begin
                    off = $urandom_range(0, IMAGE_BYTES - 1);
                end else begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: off = (base + $urandom_range(0, 31)) % (lim - n + 1);
                        3: begin
                            // straddle the end of the active area
                            off = lim - n - 2 + $urandom_range(0, 4);
                            if (off < 0) off = 0;
                            if (off > IMAGE_BYTES - 1) off = IMAGE_BYTES - 1;
                        end
                        default: off = $urandom_range(0, lim - n);
                    endcase
                end
                a.start_byte = 11'(off);
            end
        endcase
        return a;
    endfunction

    // ---------------------------------------------------------------- sender
    // Leaves s_valid high after the transfer; the caller lowers it or sends again.
    task automatic send_access(input in_t a);
        s_item  <= a;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        access_results_q.push_back(predict_access(a));
    endtask

    // Offers everything in access_q, in random bursts when bursty is set.
    task automatic pump_accesses(input bit bursty);
        int burst;
        int gap;
        while (access_q.size() > 0) begin
            burst = bursty ? $urandom_range(1, 16) : access_q.size();
            while (burst > 0 && access_q.size() > 0) begin
                send_access(access_q.pop_front());
                burst--;
            end
            gap = bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0 || access_q.size() == 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_results_drained();
        while (access_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- APB
    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(REG_ACTIVE_BYTES) << 2;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_area_reg();
        logic [31:0] rd;
        apb_transfer(1'b0, 32'd0, rd);
        if (rd !== {20'd0, area_model})
            note_error($sformatf("active_bytes readback: expected %0d, got %0h",
                                 area_model, rd));
    endtask

    // Callers only do this with nothing in flight.
    task automatic write_area(input logic [11:0] value);
        logic [31:0] rd;
        apb_transfer(1'b1, {20'($urandom), value}, rd);   // upper bits are don't-care
        area_model = value;
        check_area_reg();
    endtask

    // ---------------------------------------------------------------- receiver
    // Own random stall pattern, reloaded when its run ends; a hold request wins over it.
    always @(posedge aclk) begin
        static int          hold_left = 0;
        static int          pat_left  = 0;
        static logic [15:0] stall_pat = '1;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_left = 64;
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom) & 16'($urandom);
                    default: stall_pat = 16'($urandom);
                endcase
                stall_pat = stall_pat | (16'd1 << $urandom_range(0, 15));
            end
            m_ready   <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
        end
    end

    // ---------------------------------------------------------------- result check
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (access_results_q.size() == 0) begin
                note_error($sformatf("unexpected result read_value=%h range_error=%b",
                                     m_item.read_value, m_item.range_error));
            end else begin
                want = access_results_q.pop_front();
                if (m_item.read_value !== want.read_value ||
                    m_item.range_error !== want.range_error)
                    note_error($sformatf(
                        "result mismatch: expected value=%h err=%b, got value=%h err=%b",
                        want.read_value, want.range_error,
                        m_item.read_value, m_item.range_error));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("typed_byte_image_access_tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    // Clearing pass must leave the image zero; reads back the first and last dwords.
    task automatic test_cleared_image();
        access_q.push_back(make_access(FUNC_READ, 0, SIZE_DWORD, ORDER_BIG, 1'b0, 0, '0));
        access_q.push_back(make_access(FUNC_READ, IMAGE_BYTES - 8, SIZE_DWORD, ORDER_LITTLE,
                                       1'b1, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
    endtask

    // One dword seen through all four orders, plus word/half with sign extension.
    task automatic test_byte_orders();
        access_q.push_back(make_access(FUNC_WRITE, 16, SIZE_DWORD, ORDER_BIG, 1'b0, 0,
                                       64'h8182_8384_8586_8788));
        foreach (ORDER_CODES[i])
            access_q.push_back(make_access(FUNC_READ, 16, SIZE_DWORD, ORDER_CODES[i],
                                           1'(i), 0, '0));  // sext has no effect on dwords
        access_q.push_back(make_access(FUNC_WRITE, 33, SIZE_WORD, ORDER_LIT_WSWAP, 1'b0, 0,
                                       64'hFFFF_FFFF_8000_00FE));
        access_q.push_back(make_access(FUNC_READ, 33, SIZE_WORD, ORDER_BIG_WSWAP, 1'b1, 0, '0));
        access_q.push_back(make_access(FUNC_READ, 34, SIZE_HALF, ORDER_LITTLE, 1'b1, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
    endtask

    // Order ignored on single bytes; bit writes key on any nonzero value.
    task automatic test_byte_and_bit();
        access_q.push_back(make_access(FUNC_WRITE, IMAGE_BYTES - 1, SIZE_BYTE, ORDER_BIG_WSWAP,
                                       1'b0, 0, 64'hFFFF_FFFF_FFFF_FF80));
        access_q.push_back(make_access(FUNC_READ, IMAGE_BYTES - 1, SIZE_BYTE, ORDER_LIT_WSWAP,
                                       1'b1, 0, '0));
        access_q.push_back(make_access(FUNC_WRITE, 5, SIZE_BIT, ORDER_LITTLE, 1'b0, 7,
                                       64'h100));   // low byte zero, still sets
        access_q.push_back(make_access(FUNC_READ, 5, SIZE_BIT, ORDER_BIG, 1'b1, 7, '0));
        access_q.push_back(make_access(FUNC_WRITE, 5, SIZE_BIT, ORDER_BIG, 1'b0, 7, '0));
        access_q.push_back(make_access(FUNC_READ, 5, SIZE_BIT, ORDER_BIG, 1'b1, 7, '0));
        pump_accesses(1'b1);
        wait_results_drained();
    endtask

    // Unused size codes and an overrun are flagged and leave the image alone.
    task automatic test_flagged_access();
        for (int s = 5; s <= 7; s++)
            access_q.push_back(make_access(FUNC_WRITE, 16, 3'(s), ORDER_BIG, 1'b0, 0, '1));
        access_q.push_back(make_access(FUNC_READ, 16, SIZE_DWORD, ORDER_BIG, 1'b0, 0, '0));
        access_q.push_back(make_access(FUNC_READ, IMAGE_BYTES - 7, SIZE_DWORD, ORDER_BIG,
                                       1'b0, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
    endtask

    // Extremes of active_bytes: one byte, empty, and above the image size.
    task automatic test_area_limits();
        write_area(12'd1);
        access_q.push_back(make_access(FUNC_READ, 0, SIZE_BYTE, ORDER_BIG, 1'b0, 0, '0));
        access_q.push_back(make_access(FUNC_READ, 0, SIZE_HALF, ORDER_BIG, 1'b0, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
        write_area(12'd0);
        access_q.push_back(make_access(FUNC_READ, 0, SIZE_BIT, ORDER_BIG, 1'b0, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
        write_area(12'hFFF);
        access_q.push_back(make_access(FUNC_WRITE, IMAGE_BYTES - 1, SIZE_BYTE, ORDER_BIG,
                                       1'b0, 0, 64'h5A));
        access_q.push_back(make_access(FUNC_READ, IMAGE_BYTES - 7, SIZE_DWORD, ORDER_BIG,
                                       1'b0, 0, '0));
        pump_accesses(1'b1);
        wait_results_drained();
        write_area(12'(IMAGE_BYTES));
    endtask

    // Receiver holds off while the sender streams, so s_ready must drop.
    task automatic test_backpressure();
        int base;
        base = $urandom_range(0, IMAGE_BYTES - 64);
        hold_req = 1'b1;
        repeat (40)
            access_q.push_back(random_access(IMAGE_BYTES, base));
        pump_accesses(1'b0);
        wait_results_drained();
    endtask

    // Random traffic in phases, each under its own active_bytes setting.
    task automatic test_random_traffic();
        int area;
        int lim;
        int base;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                area = IMAGE_BYTES;
            else if ($urandom_range(0, 15) == 0)
                area = 0;
            else if ($urandom_range(0, 3) == 0)
                area = $urandom_range(1, 4095);
            else
                area = AREA_PICKS[$urandom_range(0, 7)];
            if (ph > 0)
                write_area(12'(area));
            lim  = (area > IMAGE_BYTES) ? IMAGE_BYTES : area;
            base = $urandom_range(0, IMAGE_BYTES - 1);
            repeat (PHASE_ITEMS)
                access_q.push_back(random_access(lim, base));
            pump_accesses(1'b1);
            wait_results_drained();   // sender pauses until all results are back
        end
        write_area(12'(IMAGE_BYTES));
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        foreach (image_model[i])
            image_model[i] = 8'd0;
        area_model = ACTIVE_BYTES_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_area_reg();              // reset value
        test_cleared_image();
        test_byte_orders();
        test_byte_and_bit();
        test_flagged_access();
        test_area_limits();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        if (access_results_q.size() != 0)
            note_error($sformatf("%0d results never arrived", access_results_q.size()));
        if (error_count == 0) begin
            $display("typed_byte_image_access_tb: done, clean");
        end else begin
            $display("typed_byte_image_access_tb: done, errors");
        end
        $finish;
    end

endmodule
